[rtl/grid_bilinear_interpolator_unit_macros.svh]
// assertion macros for the grid bilinear interpolator
`ifndef GRID_BILINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define GRID_BILINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define GBI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gbi same-cycle check failed");

// next-cycle implication
`define GBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gbi next-cycle check failed");

`endif

[rtl/gbi_pkg.sv]
// shared types, codes and constants of the grid bilinear interpolator
package gbi_pkg;

	// default capacities
	localparam int MAX_STRIKES_DEF    = 16;
	localparam int MAX_MATURITIES_DEF = 16;

	// field widths
	localparam int COUNT_W = 5;
	localparam int MODE_W  = 2;
	localparam int POS_W   = 4;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 1;

	// serial unit widths and step counts
	localparam int NUM_W     = 49;
	localparam int DEN_W     = 33;
	localparam int STEP_W    = 6;
	localparam int DIV_STEPS = 49;
	localparam int MUL_STEPS = 32;

	// item modes
	localparam logic [MODE_W-1:0] MODE_LOAD_STRIKE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_MATURITY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD_CELL     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY         = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO_WIDTH = 2'd2;
	localparam logic [STAT_W-1:0] ST_SATURATED  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STRIKE_COUNT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATURITY_COUNT = 1'd1;

	typedef enum logic {
		AR_OP_DIV,
		AR_OP_MUL
	} arith_op_t;

	typedef enum logic [1:0] {
		AR_IDLE,
		AR_RUN,
		AR_NEG,
		AR_OUT
	} ar_state_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_AX_START,
		SQ_SCAN_RD,
		SQ_SCAN_CMP,
		SQ_W_LO,
		SQ_W_HI,
		SQ_W_SET,
		SQ_GRID_RD,
		SQ_GRID_CAP,
		SQ_B_SET,
		SQ_AR_GO,
		SQ_AR_WAIT,
		SQ_OUT
	} seq_state_t;

	typedef enum logic [2:0] {
		PH_TX,
		PH_TY,
		PH_R1,
		PH_R2,
		PH_RES
	} phase_t;

	// request to the shared arithmetic unit
	typedef struct packed {
		logic                     start;
		arith_op_t                op;
		logic signed [NUM_W-1:0]  opa;
		logic signed [DEN_W-1:0]  opb;
		logic signed [VAL_W-1:0]  base;
	} arith_req_t;

	// response from the shared arithmetic unit
	typedef struct packed {
		logic                     done;
		logic                     sat;
		logic signed [VAL_W-1:0]  value;
	} arith_rsp_t;

endpackage

[rtl/gbi_ram.sv]
// single-port-write, registered-read memory
module gbi_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [gbi_pkg::VAL_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [gbi_pkg::VAL_W-1:0] rdata
);

	logic [gbi_pkg::VAL_W-1:0] mem [DEPTH];
	logic [gbi_pkg::VAL_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/gbi_arith.sv]
// shared serial divider and multiplier with final saturation
module gbi_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  gbi_pkg::arith_req_t req,
	output gbi_pkg::arith_rsp_t rsp
);

	gbi_pkg::ar_state_t state_q;
	gbi_pkg::arith_op_t op_q;
	logic [gbi_pkg::STEP_W-1:0] cnt_q;
	logic neg_q;
	logic [33:0] hi_q;
	logic [gbi_pkg::NUM_W-1:0] lo_q;
	logic [gbi_pkg::DEN_W-1:0] mb_q;
	logic signed [gbi_pkg::VAL_W-1:0] base_q;
	logic signed [65:0] fix_q;
	logic done_q;
	logic sat_q;
	logic signed [gbi_pkg::VAL_W-1:0] value_q;

	logic is_div;
	logic [34:0] add_a;
	logic [34:0] add_b;
	logic [34:0] sum;
	logic ge;
	logic [64:0] prod;
	logic signed [50:0] pre;

	// the one shared adder: trial subtract or accumulate
	always_comb begin
		is_div = (op_q == gbi_pkg::AR_OP_DIV);
		add_a  = is_div ? {1'b0, hi_q[32:0], lo_q[gbi_pkg::NUM_W-1]} : {1'b0, hi_q};
		add_b  = is_div ? ~{2'b0, mb_q} : (lo_q[0] ? {2'b0, mb_q} : 35'd0);
		sum    = add_a + add_b + {34'd0, is_div};
		ge     = !sum[34];
		prod   = {hi_q[32:0], lo_q[31:0]};
		if (is_div) begin
			pre = fix_q[50:0];
		end else begin
			pre = {fix_q[65], fix_q[65:16]} + {{19{base_q[31]}}, base_q};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbi_pkg::AR_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				gbi_pkg::AR_IDLE: begin
					if (req.start) begin
						state_q <= gbi_pkg::AR_RUN;
					end
				end
				gbi_pkg::AR_RUN: begin
					if (cnt_q == gbi_pkg::STEP_W'(1)) begin
						state_q <= gbi_pkg::AR_NEG;
					end
				end
				gbi_pkg::AR_NEG: begin
					state_q <= gbi_pkg::AR_OUT;
				end
				gbi_pkg::AR_OUT: begin
					state_q <= gbi_pkg::AR_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= gbi_pkg::AR_IDLE;
				end
			endcase
		end
	end

	// datapath: load magnitudes, one bit a cycle, sign, clamp
	always_ff @(posedge clk) begin
		case (state_q)
			gbi_pkg::AR_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					base_q <= req.base;
					neg_q  <= req.opa[gbi_pkg::NUM_W-1] ^ req.opb[gbi_pkg::DEN_W-1];
					lo_q   <= req.opa[gbi_pkg::NUM_W-1] ? gbi_pkg::NUM_W'(-req.opa) : req.opa;
					mb_q   <= req.opb[gbi_pkg::DEN_W-1] ? gbi_pkg::DEN_W'(-req.opb) : req.opb;
					hi_q   <= '0;
					cnt_q  <= (req.op == gbi_pkg::AR_OP_DIV) ?
						gbi_pkg::STEP_W'(gbi_pkg::DIV_STEPS) : gbi_pkg::STEP_W'(gbi_pkg::MUL_STEPS);
				end
			end
			gbi_pkg::AR_RUN: begin
				cnt_q <= cnt_q - 1'b1;
				if (is_div) begin
					hi_q <= ge ? sum[33:0] : {hi_q[32:0], lo_q[gbi_pkg::NUM_W-1]};
					lo_q <= {lo_q[gbi_pkg::NUM_W-2:0], ge};
				end else begin
					hi_q <= sum[34:1];
					lo_q <= {17'd0, sum[0], lo_q[31:1]};
				end
			end
			gbi_pkg::AR_NEG: begin
				if (is_div) begin
					fix_q <= neg_q ? -$signed({17'd0, lo_q}) : $signed({17'd0, lo_q});
				end else begin
					fix_q <= neg_q ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
				end
			end
			gbi_pkg::AR_OUT: begin
				if (pre > 51'sd2147483647) begin
					value_q <= 32'sh7fffffff;
					sat_q   <= 1'b1;
				end else if (pre < -51'sd2147483648) begin
					value_q <= 32'sh80000000;
					sat_q   <= 1'b1;
				end else begin
					value_q <= pre[31:0];
					sat_q   <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.sat   = sat_q;
	assign rsp.value = value_q;

endmodule

[rtl/grid_bilinear_interpolator_unit.sv]
// Loads (strike, maturity, grid cell) leave the block idle; it is ready the next cycle.
// A query runs up to two axis scans that read and compare one entry at a time, up to two
// serial divisions at one quotient bit per cycle and three serial multiplies at one bit per
// cycle; the divisions and multiplies all run on one shared adder.
// One query is in flight at a time; the result waits in an output register.
// arst_n clears the sequencer and both counts; axis and grid memories are not cleared.
module grid_bilinear_interpolator_unit #(
	parameter int MAX_STRIKES    = gbi_pkg::MAX_STRIKES_DEF,
	parameter int MAX_MATURITIES = gbi_pkg::MAX_MATURITIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write_en,
	input  logic [gbi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gbi_pkg::COUNT_W-1:0]       cfg_data,
	// item channel
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [gbi_pkg::MODE_W-1:0]        mode,
	input  logic [gbi_pkg::POS_W-1:0]         row_index,
	input  logic [gbi_pkg::POS_W-1:0]         col_index,
	input  logic signed [gbi_pkg::VAL_W-1:0]  load_value,
	input  logic signed [gbi_pkg::VAL_W-1:0]  query_strike,
	input  logic signed [gbi_pkg::VAL_W-1:0]  query_maturity,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [gbi_pkg::VAL_W-1:0]  interp_value,
	output logic [gbi_pkg::STAT_W-1:0]        status
);

	localparam int SAW  = $clog2(MAX_STRIKES);
	localparam int MAW  = $clog2(MAX_MATURITIES);
	localparam int GDEP = MAX_STRIKES * MAX_MATURITIES;
	localparam int GAW  = $clog2(GDEP);
	localparam int MAXN = (MAX_STRIKES > MAX_MATURITIES) ? MAX_STRIKES : MAX_MATURITIES;
	localparam int CW   = $clog2(MAXN + 1);

	gbi_pkg::seq_state_t state_q, state_d;
	gbi_pkg::phase_t phase_q, phase_d;
	logic [gbi_pkg::COUNT_W-1:0] strike_count_q;
	logic [gbi_pkg::COUNT_W-1:0] maturity_count_q;

	logic [CW-1:0] cnt_q;
	logic [1:0] gcnt_q;
	logic signed [gbi_pkg::VAL_W-1:0] x_q, y_q, a1_q, tx_q, ty_q, r1_q, res_q;
	logic signed [gbi_pkg::VAL_W-1:0] g_q [4];
	logic [CW-1:0] ns_q, nm_q;
	logic [SAW-1:0] xlo_q, xhi_q;
	logic [MAW-1:0] ylo_q, yhi_q;
	logic [gbi_pkg::STAT_W-1:0] status_q;
	logic zero_q, sat_q;
	gbi_pkg::arith_op_t op_q;
	logic signed [gbi_pkg::NUM_W-1:0] opa_q;
	logic signed [gbi_pkg::DEN_W-1:0] opb_q;
	logic signed [gbi_pkg::VAL_W-1:0] base_q;

	logic accept;
	logic [CW-1:0] ns_c, nm_c, cur_n, cnt_inc, seg_hi, seg_lo;
	logic signed [gbi_pkg::VAL_W-1:0] cur_c, ax_rd, str_rd, mat_rd, grid_rd;
	logic below, last, is_ty;
	logic signed [gbi_pkg::DEN_W-1:0] num_d, den_d;
	logic [SAW-1:0] str_raddr, gr_row;
	logic [MAW-1:0] mat_raddr, gr_col;
	logic [GAW-1:0] grid_raddr, grid_waddr;
	logic str_we, mat_we, grid_we;
	gbi_pkg::arith_req_t ar_req;
	gbi_pkg::arith_rsp_t ar_rsp;

	// handshake and load strobes
	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != gbi_pkg::SQ_IDLE);
	assign str_we  = accept && (mode == gbi_pkg::MODE_LOAD_STRIKE) &&
		(32'(row_index) < MAX_STRIKES);
	assign mat_we  = accept && (mode == gbi_pkg::MODE_LOAD_MATURITY) &&
		(32'(col_index) < MAX_MATURITIES);
	assign grid_we = accept && (mode == gbi_pkg::MODE_LOAD_CELL) &&
		(32'(row_index) < MAX_STRIKES) && (32'(col_index) < MAX_MATURITIES);
	assign grid_waddr = GAW'(32'(row_index) * MAX_MATURITIES + 32'(col_index));

	// axis counts limited to capacity
	assign ns_c = (32'(strike_count_q) > MAX_STRIKES) ? CW'(MAX_STRIKES) : CW'(strike_count_q);
	assign nm_c = (32'(maturity_count_q) > MAX_MATURITIES) ?
		CW'(MAX_MATURITIES) : CW'(maturity_count_q);

	// current axis selection and scan compare
	always_comb begin
		is_ty   = (phase_q == gbi_pkg::PH_TY);
		cur_c   = is_ty ? y_q : x_q;
		cur_n   = is_ty ? nm_q : ns_q;
		ax_rd   = is_ty ? mat_rd : str_rd;
		cnt_inc = cnt_q + 1'b1;
		below   = ax_rd < cur_c;
		last    = (cnt_inc == cur_n);
		seg_hi  = (cnt_q == '0) ? CW'(1) : cnt_q;
		seg_lo  = seg_hi - 1'b1;
		num_d   = {cur_c[31], cur_c} - {a1_q[31], a1_q};
		den_d   = {ax_rd[31], ax_rd} - {a1_q[31], a1_q};
	end

	// memory read addresses
	always_comb begin
		str_raddr = cnt_q[SAW-1:0];
		mat_raddr = cnt_q[MAW-1:0];
		if (state_q == gbi_pkg::SQ_W_LO) begin
			str_raddr = xlo_q;
			mat_raddr = ylo_q;
		end else if (state_q == gbi_pkg::SQ_W_HI) begin
			str_raddr = xhi_q;
			mat_raddr = yhi_q;
		end
		gr_row     = gcnt_q[0] ? xhi_q : xlo_q;
		gr_col     = gcnt_q[1] ? yhi_q : ylo_q;
		grid_raddr = GAW'(32'(gr_row) * MAX_MATURITIES + 32'(gr_col));
	end

	gbi_ram #(.DEPTH(MAX_STRIKES)) u_strike_ram (
		.clk   (clk),
		.we    (str_we),
		.waddr (SAW'(row_index)),
		.wdata (load_value),
		.raddr (str_raddr),
		.rdata (str_rd)
	);

	gbi_ram #(.DEPTH(MAX_MATURITIES)) u_maturity_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (MAW'(col_index)),
		.wdata (load_value),
		.raddr (mat_raddr),
		.rdata (mat_rd)
	);

	gbi_ram #(.DEPTH(GDEP)) u_grid_ram (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (load_value),
		.raddr (grid_raddr),
		.rdata (grid_rd)
	);

	// shared arithmetic unit
	always_comb begin
		ar_req.start = (state_q == gbi_pkg::SQ_AR_GO);
		ar_req.op    = op_q;
		ar_req.opa   = opa_q;
		ar_req.opb   = opb_q;
		ar_req.base  = base_q;
	end

	gbi_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.rsp    (ar_rsp)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			gbi_pkg::SQ_IDLE: begin
				if (accept && (mode == gbi_pkg::MODE_QUERY)) begin
					phase_d = gbi_pkg::PH_TX;
					state_d = ((ns_c == '0) || (nm_c == '0)) ?
						gbi_pkg::SQ_OUT : gbi_pkg::SQ_AX_START;
				end
			end
			gbi_pkg::SQ_AX_START: begin
				if (cur_n < CW'(2)) begin
					phase_d = gbi_pkg::PH_TY;
					state_d = is_ty ? gbi_pkg::SQ_GRID_RD : gbi_pkg::SQ_AX_START;
				end else begin
					state_d = gbi_pkg::SQ_SCAN_RD;
				end
			end
			gbi_pkg::SQ_SCAN_RD: begin
				state_d = gbi_pkg::SQ_SCAN_CMP;
			end
			gbi_pkg::SQ_SCAN_CMP: begin
				state_d = (below && !last) ? gbi_pkg::SQ_SCAN_RD : gbi_pkg::SQ_W_LO;
			end
			gbi_pkg::SQ_W_LO: begin
				state_d = gbi_pkg::SQ_W_HI;
			end
			gbi_pkg::SQ_W_HI: begin
				state_d = gbi_pkg::SQ_W_SET;
			end
			gbi_pkg::SQ_W_SET: begin
				if (ax_rd == a1_q) begin
					phase_d = gbi_pkg::PH_TY;
					state_d = is_ty ? gbi_pkg::SQ_GRID_RD : gbi_pkg::SQ_AX_START;
				end else begin
					state_d = gbi_pkg::SQ_AR_GO;
				end
			end
			gbi_pkg::SQ_GRID_RD: begin
				state_d = gbi_pkg::SQ_GRID_CAP;
			end
			gbi_pkg::SQ_GRID_CAP: begin
				if (gcnt_q == 2'd3) begin
					phase_d = gbi_pkg::PH_R1;
					state_d = gbi_pkg::SQ_B_SET;
				end else begin
					state_d = gbi_pkg::SQ_GRID_RD;
				end
			end
			gbi_pkg::SQ_B_SET: begin
				state_d = gbi_pkg::SQ_AR_GO;
			end
			gbi_pkg::SQ_AR_GO: begin
				state_d = gbi_pkg::SQ_AR_WAIT;
			end
			gbi_pkg::SQ_AR_WAIT: begin
				if (ar_rsp.done) begin
					case (phase_q)
						gbi_pkg::PH_TX: begin
							phase_d = gbi_pkg::PH_TY;
							state_d = gbi_pkg::SQ_AX_START;
						end
						gbi_pkg::PH_TY: begin
							state_d = gbi_pkg::SQ_GRID_RD;
						end
						gbi_pkg::PH_R1: begin
							phase_d = gbi_pkg::PH_R2;
							state_d = gbi_pkg::SQ_B_SET;
						end
						gbi_pkg::PH_R2: begin
							phase_d = gbi_pkg::PH_RES;
							state_d = gbi_pkg::SQ_B_SET;
						end
						default: begin
							state_d = gbi_pkg::SQ_OUT;
						end
					endcase
				end
			end
			gbi_pkg::SQ_OUT: begin
				if (!result_stall) begin
					state_d = gbi_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = gbi_pkg::SQ_IDLE;
			end
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= gbi_pkg::SQ_IDLE;
			phase_q          <= gbi_pkg::PH_TX;
			strike_count_q   <= '0;
			maturity_count_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cfg_write_en) begin
				case (cfg_index)
					gbi_pkg::REG_STRIKE_COUNT:   strike_count_q   <= cfg_data;
					gbi_pkg::REG_MATURITY_COUNT: maturity_count_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			gbi_pkg::SQ_IDLE: begin
				if (accept) begin
					x_q      <= query_strike;
					y_q      <= query_maturity;
					ns_q     <= ns_c;
					nm_q     <= nm_c;
					zero_q   <= 1'b0;
					sat_q    <= 1'b0;
					res_q    <= '0;
					status_q <= gbi_pkg::ST_EMPTY;
				end
			end
			gbi_pkg::SQ_AX_START: begin
				cnt_q  <= '0;
				gcnt_q <= '0;
				if (cur_n < CW'(2)) begin
					if (is_ty) begin
						ylo_q <= '0;
						yhi_q <= '0;
						ty_q  <= '0;
					end else begin
						xlo_q <= '0;
						xhi_q <= '0;
						tx_q  <= '0;
					end
				end
			end
			gbi_pkg::SQ_SCAN_CMP: begin
				cnt_q <= cnt_inc;
				if (is_ty) begin
					ylo_q <= seg_lo[MAW-1:0];
					yhi_q <= seg_hi[MAW-1:0];
				end else begin
					xlo_q <= seg_lo[SAW-1:0];
					xhi_q <= seg_hi[SAW-1:0];
				end
			end
			gbi_pkg::SQ_W_HI: begin
				a1_q <= ax_rd;
			end
			gbi_pkg::SQ_W_SET: begin
				if (ax_rd == a1_q) begin
					// flat segment: weight zero, lower entry
					zero_q <= 1'b1;
					if (is_ty) begin
						ty_q <= '0;
					end else begin
						tx_q <= '0;
					end
				end else begin
					op_q  <= gbi_pkg::AR_OP_DIV;
					opa_q <= {num_d, 16'd0};
					opb_q <= den_d;
				end
			end
			gbi_pkg::SQ_GRID_CAP: begin
				g_q[gcnt_q] <= grid_rd;
				gcnt_q      <= gcnt_q + 1'b1;
			end
			gbi_pkg::SQ_B_SET: begin
				op_q <= gbi_pkg::AR_OP_MUL;
				case (phase_q)
					gbi_pkg::PH_R1: begin
						opa_q  <= gbi_pkg::NUM_W'(tx_q);
						opb_q  <= {g_q[1][31], g_q[1]} - {g_q[0][31], g_q[0]};
						base_q <= g_q[0];
					end
					gbi_pkg::PH_R2: begin
						opa_q  <= gbi_pkg::NUM_W'(tx_q);
						opb_q  <= {g_q[3][31], g_q[3]} - {g_q[2][31], g_q[2]};
						base_q <= g_q[2];
					end
					default: begin
						opa_q  <= gbi_pkg::NUM_W'(ty_q);
						opb_q  <= {ty_q[31] & 1'b0, 32'sd0} + {res_q[31], res_q}
							- {r1_q[31], r1_q};
						base_q <= r1_q;
					end
				endcase
			end
			gbi_pkg::SQ_AR_WAIT: begin
				if (ar_rsp.done) begin
					sat_q <= sat_q | ar_rsp.sat;
					case (phase_q)
						gbi_pkg::PH_TX: tx_q <= ar_rsp.value;
						gbi_pkg::PH_TY: ty_q <= ar_rsp.value;
						gbi_pkg::PH_R1: r1_q <= ar_rsp.value;
						// second column result parks in res_q until the last blend
						gbi_pkg::PH_R2: res_q <= ar_rsp.value;
						default: begin
							res_q    <= ar_rsp.value;
							status_q <= zero_q ? gbi_pkg::ST_ZERO_WIDTH :
								((sat_q | ar_rsp.sat) ? gbi_pkg::ST_SATURATED : gbi_pkg::ST_OK);
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// result beat
	assign result_valid = (state_q == gbi_pkg::SQ_OUT);
	assign interp_value = res_q;
	assign status       = status_q;

	`include "grid_bilinear_interpolator_unit_macros.svh"

	`GBI_ASSERT_SAME(a_result_blocks_items, clk, arst_n, result_valid, item_stall)
	`GBI_ASSERT_NEXT(a_one_result_per_query, clk, arst_n, result_valid && !result_stall, !result_valid)
	`GBI_ASSERT_SAME(a_empty_gives_zero, clk, arst_n, result_valid && (status == gbi_pkg::ST_EMPTY), interp_value == 32'sd0)
	`GBI_ASSERT_SAME(a_arith_done_expected, clk, arst_n, ar_rsp.done, state_q == gbi_pkg::SQ_AR_WAIT)

endmodule

[verif/gbi_checker.sv]
// checker for the grid bilinear interpolator: tracks state, predicts and compares results
`timescale 1ns / 1ps

module gbi_checker
	import gbi_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [COUNT_W-1:0]        cfg_data,
	input  logic                      item_valid,
	input  logic                      item_stall,
	input  logic [MODE_W-1:0]         mode,
	input  logic [POS_W-1:0]          row_index,
	input  logic [POS_W-1:0]          col_index,
	input  logic signed [VAL_W-1:0]   load_value,
	input  logic signed [VAL_W-1:0]   query_strike,
	input  logic signed [VAL_W-1:0]   query_maturity,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic signed [VAL_W-1:0]   interp_value,
	input  logic [STAT_W-1:0]         status,
	output int                        fail_count,
	output int                        pending
);

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [STAT_W-1:0]       stat;
	} interp_result_t;

	// shadow of the block's tables and counts
	logic signed [VAL_W-1:0] strikes [16];
	logic signed [VAL_W-1:0] maturities [16];
	logic signed [VAL_W-1:0] cells [16][16];
	logic [COUNT_W-1:0]      strike_cnt, maturity_cnt;
	interp_result_t          expected_results [$];

	function automatic longint clamp_q16(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// first entry not below c, pulled into 1..n-1
	function automatic void find_span(input bit on_strike, input longint c, input int n,
			output int lo, output int hi);
		int i;
		longint a;
		i = 0;
		if (n < 2) begin
			lo = 0;
			hi = 0;
			return;
		end
		while (i < n) begin
			a = on_strike ? strikes[i] : maturities[i];
			if (a >= c) break;
			i++;
		end
		if (i == 0) i = 1;
		if (i == n) i = n - 1;
		lo = i - 1;
		hi = i;
	endfunction

	function automatic longint span_weight(input longint c, input longint a1, input longint a2,
			inout bit zero, inout bit sat);
		if (a1 == a2) begin
			zero = 1;
			return 0;
		end
		return clamp_q16(((c - a1) * 65536) / (a2 - a1), sat);
	endfunction

	function automatic longint lerp_q16(input longint qa, input longint qb, input longint t,
			inout bit sat);
		return clamp_q16(qa + ((t * (qb - qa)) >>> 16), sat);
	endfunction

	function automatic interp_result_t interpolate(input longint x, input longint y);
		interp_result_t r;
		int ns, nm, x1, x2, y1, y2;
		bit zero, sat;
		longint tx, ty, r1, r2;
		zero = 0;
		sat = 0;
		ns = strike_cnt > 16 ? 16 : strike_cnt;
		nm = maturity_cnt > 16 ? 16 : maturity_cnt;
		if (ns == 0 || nm == 0) begin
			r.value = '0;
			r.stat = ST_EMPTY;
			return r;
		end
		find_span(1'b1, x, ns, x1, x2);
		find_span(1'b0, y, nm, y1, y2);
		tx = (ns < 2) ? 0 : span_weight(x, strikes[x1], strikes[x2], zero, sat);
		ty = (nm < 2) ? 0 : span_weight(y, maturities[y1], maturities[y2], zero, sat);
		r1 = lerp_q16(cells[x1][y1], cells[x2][y1], tx, sat);
		r2 = lerp_q16(cells[x1][y2], cells[x2][y2], tx, sat);
		r.value = VAL_W'(lerp_q16(r1, r2, ty, sat));
		r.stat = zero ? ST_ZERO_WIDTH : (sat ? ST_SATURATED : ST_OK);
		return r;
	endfunction

	assign pending = expected_results.size();

	// register writes, item beats and result beats
	always @(posedge clk or negedge arst_n) begin
		interp_result_t e;
		if (!arst_n) begin
			strike_cnt <= '0;
			maturity_cnt <= '0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_write_en) begin
				if (cfg_index == REG_STRIKE_COUNT) strike_cnt <= cfg_data;
				else if (cfg_index == REG_MATURITY_COUNT) maturity_cnt <= cfg_data;
			end
			if (item_valid && !item_stall) begin
				case (mode)
					MODE_LOAD_STRIKE: strikes[row_index] = load_value;
					MODE_LOAD_MATURITY: maturities[col_index] = load_value;
					MODE_LOAD_CELL: cells[row_index][col_index] = load_value;
					default: expected_results = {expected_results,
						interpolate(query_strike, query_maturity)};
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no query outstanding");
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (interp_value !== e.value) begin
						$error("interp_value: expected %0d, got %0d", e.value, interp_value);
						fail_count++;
					end
					if (status !== e.stat) begin
						$error("status: expected %0d, got %0d", e.stat, status);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

[verif/tb_grid_bilinear_interpolator_unit.sv]
// testbench top for the grid bilinear interpolator: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_grid_bilinear_interpolator_unit;
	import gbi_pkg::*;

	localparam int ITEM_TARGET = 1250;
	localparam int STALL_LIMIT = 20000;

	logic clk, arst_n;
	logic cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COUNT_W-1:0] cfg_data;
	logic item_valid, item_stall;
	logic [MODE_W-1:0] mode;
	logic [POS_W-1:0] row_index, col_index;
	logic signed [VAL_W-1:0] load_value, query_strike, query_maturity;
	logic result_valid, result_stall;
	logic signed [VAL_W-1:0] interp_value;
	logic [STAT_W-1:0] status;
	int fail_count, pending;
	int items_sent, idle_cycles;
	bit calm;
	logic signed [VAL_W-1:0] strike_pts [16];
	logic signed [VAL_W-1:0] maturity_pts [16];

	grid_bilinear_interpolator_unit dut (.*);

	gbi_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// result-side stalls
	always @(posedge clk) result_stall <= !calm && ($urandom_range(99) < 34);

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_beat(input logic [MODE_W-1:0] m, input int r, input int c,
			input logic signed [VAL_W-1:0] v, input logic signed [VAL_W-1:0] qs,
			input logic signed [VAL_W-1:0] qm);
		if (!calm && $urandom_range(99) < 34) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		row_index <= POS_W'(r);
		col_index <= POS_W'(c);
		load_value <= v;
		query_strike <= qs;
		query_maturity <= qm;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic load_strike(input int i, input logic signed [VAL_W-1:0] v);
		strike_pts[i] = v;
		send_beat(MODE_LOAD_STRIKE, i, $urandom_range(15), v, $urandom, $urandom);
	endtask

	task automatic load_maturity(input int i, input logic signed [VAL_W-1:0] v);
		maturity_pts[i] = v;
		send_beat(MODE_LOAD_MATURITY, $urandom_range(15), i, v, $urandom, $urandom);
	endtask

	task automatic query(input logic signed [VAL_W-1:0] qs, input logic signed [VAL_W-1:0] qm);
		send_beat(MODE_QUERY, $urandom_range(15), $urandom_range(15), $urandom, qs, qm);
	endtask

	// drain outstanding results, let any load finish, then write the counts
	task automatic set_counts(input int ns, input int nm);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_STRIKE_COUNT;
		cfg_data <= COUNT_W'(ns);
		@(posedge clk);
		cfg_index <= REG_MATURITY_COUNT;
		cfg_data <= COUNT_W'(nm);
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// ascending axis value for slot i, sometimes equal to its neighbor
	function automatic logic signed [VAL_W-1:0] next_point(input logic signed [VAL_W-1:0] prev);
		if ($urandom_range(9) == 0) return prev;
		return prev + ($urandom_range(1, 6) <<< 16) + $urandom_range(65535);
	endfunction

	// coordinate near an axis point, or anywhere
	function automatic logic signed [VAL_W-1:0] pick_coord(input bit on_strike);
		logic signed [VAL_W-1:0] p;
		p = on_strike ? strike_pts[$urandom_range(15)] : maturity_pts[$urandom_range(15)];
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return p;
			default: return p + $signed($urandom_range(0, 20 << 16)) - (10 << 16);
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_cell();
		case ($urandom_range(7))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return $signed($urandom_range(0, 200 << 16)) - (100 << 16);
		endcase
	endfunction

	task automatic random_phase(input int upto);
		int k;
		while (items_sent < upto) begin
			k = $urandom_range(99);
			if (k < 55) query(pick_coord(1'b1), pick_coord(1'b0));
			else if (k < 62) load_strike($urandom_range(15), $urandom_range(1) ?
				strike_pts[$urandom_range(15)] : $urandom);
			else if (k < 69) load_maturity($urandom_range(15), $urandom_range(1) ?
				maturity_pts[$urandom_range(15)] : $urandom);
			else send_beat(MODE_LOAD_CELL, $urandom_range(15), $urandom_range(15),
				pick_cell(), $urandom, $urandom);
		end
	endtask

	initial begin
		logic signed [VAL_W-1:0] p;
		calm = 0;
		items_sent = 0;
		idle_cycles = 0;
		cfg_write_en = 0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 0;
		mode = MODE_LOAD_STRIKE;
		row_index = '0;
		col_index = '0;
		load_value = '0;
		query_strike = '0;
		query_maturity = '0;
		result_stall = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty axes give a zero result
		query(32'sh7fffffff, 32'sh80000000);
		query(0, 0);

		// fill both axes and the whole grid
		p = -(20 << 16);
		for (int i = 0; i < 16; i++) begin
			p = (i == 0) ? p : next_point(p);
			load_strike(i, p);
		end
		p = $signed($urandom_range(0, 3 << 16));
		for (int i = 0; i < 16; i++) begin
			p = (i == 0) ? p : next_point(p);
			load_maturity(i, p);
		end
		for (int r = 0; r < 16; r++)
			for (int c = 0; c < 16; c++)
				send_beat(MODE_LOAD_CELL, r, c, pick_cell(), $urandom, $urandom);
		// forced equal neighbors on the strike axis
		load_strike(5, strike_pts[4]);

		// single entry on each axis
		set_counts(1, 1);
		query(12345, -777);
		query(32'sh7fffffff, 32'sh80000000);

		// full grid: extremes, on-point, outside and duplicate segment
		set_counts(16, 16);
		query(32'sh80000000, 32'sh80000000);
		query(32'sh7fffffff, 32'sh7fffffff);
		query(strike_pts[0], maturity_pts[15]);
		query(strike_pts[15] + (50 << 16), maturity_pts[7]);
		query(strike_pts[4], maturity_pts[3] + 1);
		query(strike_pts[0] - (30 << 16), maturity_pts[0] - (9 << 16));
		random_phase(600);

		// strike count above capacity, no idling on either side
		set_counts(31, 2);
		calm = 1;
		random_phase(750);
		calm = 0;

		set_counts(16, 1);
		random_phase(900);
		set_counts(2, 16);
		random_phase(1050);
		set_counts(0, 9);
		query(pick_coord(1'b1), pick_coord(1'b0));
		set_counts(7, 5);
		random_phase(ITEM_TARGET);

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/gbi_pkg.sv
rtl/gbi_ram.sv
rtl/gbi_arith.sv
rtl/grid_bilinear_interpolator_unit.sv
verif/gbi_checker.sv
verif/tb_grid_bilinear_interpolator_unit.sv
